[design/u8gb_pkg.sv]
// ---------------------------------------------------------------------------
// u8gb_pkg: shared types and constants of the UTF-8 to GB2312 transcoder
// Item opcodes, register indexes, byte-class masks, the command passed from
// the front end to the search engine, the result item and engine states.
// ---------------------------------------------------------------------------
package u8gb_pkg;

    // Input item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Register index (word address) of table_entries
    localparam logic REG_TABLE_ENTRIES = 1'b0;

    // Byte classes
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_EMIT,
        CMD_LOOKUP
    } cmd_kind_t;

    // One unit of work for the back end. For CMD_EMIT the byte sits in key[7:0].
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] key;
        logic [15:0] code;
        logic [12:0] index;
        logic        err;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       miss;
        logic       err;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROBE,
        BK_COMPARE,
        BK_EMIT_HI,
        BK_EMIT_LO
    } back_state_t;

    // Count the leading ones of a byte (0 to 8).
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i])
            begin
                n = n + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

[design/u8gb_ram.sv]
// ---------------------------------------------------------------------------
// u8gb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module u8gb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/u8gb_fifo.sv]
// ---------------------------------------------------------------------------
// u8gb_fifo: small register queue
// Depth must be a power of two; pointers wrap naturally.
// ---------------------------------------------------------------------------
module u8gb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + (PW+1)'(1)))
        else $error("queue count did not advance on write");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue both full and empty");

endmodule

[design/u8gb_front.sv]
// ---------------------------------------------------------------------------
// u8gb_front: item classifier and UTF-8 sequence assembler
// Turns each accepted item into at most one command for the back end.
// ---------------------------------------------------------------------------
module u8gb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            opcode,
    input  logic [7:0]      data_byte,
    input  logic            end_of_chunk,
    input  logic [12:0]     entry_index,
    input  logic [15:0]     entry_unicode,
    input  logic [15:0]     entry_gb,
    output logic            cmd_push,
    output u8gb_pkg::cmd_t  cmd
);
    import u8gb_pkg::*;

    logic [15:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic        drop_reg, drop_next;
    logic [3:0]  n_ones;
    logic [15:0] acc_shift;
    logic [7:0]  lead_mask;

    assign n_ones    = lead_ones(data_byte);
    assign acc_shift = {acc_reg[9:0], data_byte[5:0] & PAYLOAD_MASK[5:0]};
    assign lead_mask = 8'(8'hFF >> (n_ones + 4'd1));

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        drop_next = drop_reg;
        cmd_push  = 1'b0;
        cmd.kind  = CMD_EMIT;
        cmd.key   = {8'h00, data_byte};
        cmd.code  = entry_gb;
        cmd.index = entry_index;
        cmd.err   = 1'b0;

        if (accept && opcode == OP_LOAD)
        begin
            cmd_push = 1'b1;
            cmd.kind = CMD_LOAD;
            cmd.key  = entry_unicode;
        end
        else if (accept)
        begin
            if (drop_reg)
            begin
                // drop silently until chunk end
            end
            else if (rem_reg != 3'd0)
            begin
                if ((data_byte & CONT_MASK) != CONT_TAG)
                begin
                    cmd_push  = 1'b1;
                    cmd.key   = 16'h0000;
                    cmd.err   = 1'b1;
                    acc_next  = 16'h0000;
                    rem_next  = 3'd0;
                    drop_next = 1'b1;
                end
                else if (rem_reg == 3'd1)
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_LOOKUP;
                    cmd.key  = acc_shift;
                    acc_next = 16'h0000;
                    rem_next = 3'd0;
                end
                else
                begin
                    acc_next = acc_shift;
                    rem_next = rem_reg - 3'd1;
                end
            end
            else if (n_ones <= 4'd1)
            begin
                // plain ASCII or stray continuation: pass through
                cmd_push = 1'b1;
            end
            else if (n_ones <= 4'd6)
            begin
                acc_next = {8'h00, data_byte & lead_mask};
                rem_next = 3'(n_ones - 4'd1);
            end
            else
            begin
                cmd_push  = 1'b1;
                cmd.key   = 16'h0000;
                cmd.err   = 1'b1;
                drop_next = 1'b1;
            end

            if (end_of_chunk)
            begin
                drop_next = 1'b0;
                rem_next  = 3'd0;
                acc_next  = 16'h0000;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 16'h0000;
            rem_reg  <= 3'd0;
            drop_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            drop_reg <= drop_next;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("pending continuation count out of range");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> rem_reg == 3'd0)
        else $error("sequence pending while dropping");

    a_eoc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_DATA && end_of_chunk)
            |=> (!drop_reg && rem_reg == 3'd0))
        else $error("chunk end did not clear state");

endmodule

[design/u8gb_back.sv]
// ---------------------------------------------------------------------------
// u8gb_back: table writer and binary-search engine
// Executes commands in order: writes table entries, forwards single results
// and runs a binary search over the table for each assembled code point.
// ---------------------------------------------------------------------------
module u8gb_back #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [13:0]       table_entries,
    input  u8gb_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output u8gb_pkg::result_t res
);
    import u8gb_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (NW > 14) ? NW : 14;
    localparam int IW = (NW > 13) ? NW : 13;

    back_state_t state_reg, state_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [15:0]   key_reg, key_next;
    logic [15:0]   code_reg, code_next;
    logic          miss_reg, miss_next;

    logic [WW-1:0] te_wide;
    logic [WW-1:0] te_limit;
    logic [NW-1:0] n_entries;
    logic [IW-1:0] idx_wide;
    logic          idx_in_range;
    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid_calc;
    logic          ram_we;
    logic [31:0]   ram_rdata;
    logic [15:0]   probe_key;

    // Clamp the searched range to the table depth.
    assign te_wide   = WW'(table_entries);
    assign te_limit  = (te_wide > WW'(TABLE_DEPTH)) ? WW'(TABLE_DEPTH) : te_wide;
    assign n_entries = te_limit[NW-1:0];

    assign idx_wide     = IW'(cmd.index);
    assign idx_in_range = idx_wide < IW'(TABLE_DEPTH);

    // Midpoint of [lo, hi-1]; used only while lo < hi.
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - (NW+1)'(1);
    assign mid_calc  = mid_sum[NW:1];
    assign probe_key = ram_rdata[31:16];

    u8gb_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(idx_wide[AW-1:0]),
        .wdata({cmd.key, cmd.code}),
        .raddr(mid_calc[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        code_next    = code_reg;
        miss_next    = miss_reg;
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;
        res_push     = 1'b0;
        res.out_byte = code_reg[15:8];
        res.last     = 1'b0;
        res.miss     = miss_reg;
        res.err      = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        CMD_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            ram_we  = idx_in_range;
                        end
                        CMD_EMIT:
                        begin
                            res.out_byte = cmd.key[7:0];
                            res.last     = 1'b1;
                            res.miss     = 1'b0;
                            res.err      = cmd.err;
                            if (!res_full)
                            begin
                                res_push = 1'b1;
                                cmd_pop  = 1'b1;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            cmd_pop    = 1'b1;
                            key_next   = cmd.key;
                            lo_next    = '0;
                            hi_next    = n_entries;
                            state_next = BK_PROBE;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_PROBE:
            begin
                if (lo_reg >= hi_reg)
                begin
                    code_next  = 16'h0000;
                    miss_next  = 1'b1;
                    state_next = BK_EMIT_HI;
                end
                else
                begin
                    mid_next   = mid_calc[AW-1:0];
                    state_next = BK_COMPARE;
                end
            end
            BK_COMPARE:
            begin
                if (probe_key == key_reg)
                begin
                    code_next  = ram_rdata[15:0];
                    miss_next  = 1'b0;
                    state_next = BK_EMIT_HI;
                end
                else if (probe_key < key_reg)
                begin
                    lo_next    = NW'(mid_reg) + NW'(1);
                    state_next = BK_PROBE;
                end
                else
                begin
                    hi_next    = NW'(mid_reg);
                    state_next = BK_PROBE;
                end
            end
            BK_EMIT_HI:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_EMIT_LO;
                end
            end
            BK_EMIT_LO:
            begin
                res.out_byte = code_reg[7:0];
                res.last     = 1'b1;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        code_reg <= code_next;
        miss_reg <= miss_next;
    end

    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_PROBE) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_compare_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_COMPARE) |-> ($past(state_reg) == BK_PROBE))
        else $error("compare without a probe read");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (!cmd_empty && state_reg == BK_IDLE))
        else $error("command popped outside idle or from empty queue");

endmodule

[design/utf8_to_gb2312_transcoder.sv]
// ---------------------------------------------------------------------------
// utf8_to_gb2312_transcoder: UTF-8 byte stream to GB2312 converter
// Front end classifies bytes and loads, back end searches the code table.
// ---------------------------------------------------------------------------
// Items are either table loads (opcode 0: entry_index, entry_unicode,
// entry_gb) or UTF-8 data bytes (opcode 1). ASCII and stray continuation
// bytes come out unchanged in one result. A multi-byte sequence produces
// nothing until its final byte, then two results: the GB2312 code high byte
// first, or two zero bytes with lookup_miss set when the code point is not in
// the table. A malformed byte gives one result with seq_error set, after
// which data bytes are dropped until end_of_chunk. The table must be loaded
// sorted ascending by Unicode value and table_entries set (address 0) before
// data is sent; the user must write configuration only while the block is
// idle, which the block itself does not enforce. The front end takes one
// item per cycle, while the command queue has room, into a two-entry
// command queue. A load or single-byte result is handled in the back end's
// idle state. Per binary-search probe a lookup passes BK_PROBE, which
// addresses the table RAM, and BK_COMPARE, which checks its registered
// read data; it then emits both result bytes from BK_EMIT_HI and BK_EMIT_LO.
// The table has no reset: search only loaded entries.
// ---------------------------------------------------------------------------
module utf8_to_gb2312_transcoder #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    input  logic        end_of_chunk,
    input  logic [12:0] entry_index,
    input  logic [15:0] entry_unicode,
    input  logic [15:0] entry_gb,
    // result items
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        lookup_miss,
    output logic        seq_error
);
    import u8gb_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

    logic [13:0]      table_entries_reg;
    logic             cfg_write;
    logic             reg_sel;

    logic             in_accept;
    logic             cmd_push;
    cmd_t             cmd_in;
    cmd_t             cmd_out;
    logic [CMD_W-1:0] cmd_rdata;
    logic             cmd_empty;
    logic             cmd_pop;

    logic             res_push;
    logic             res_full;
    result_t          res_in;
    result_t          res_out;
    logic [RES_W-1:0] res_rdata;

    // Configuration port: register i lives at byte address 4*i; always ready.
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == REG_TABLE_ENTRIES);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_sel ? {18'h00000, table_entries_reg} : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_entries_reg <= 14'd0;
        end
        else if (cfg_write && reg_sel)
        begin
            table_entries_reg <= pwdata[13:0];
        end
    end

    // Accept an item whenever the command queue has room, even for items
    // that produce no command.
    assign in_accept = push && !full;

    u8gb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .end_of_chunk (end_of_chunk),
        .entry_index  (entry_index),
        .entry_unicode(entry_unicode),
        .entry_gb     (entry_gb),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    // Decouple classification from the search engine.
    u8gb_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(2)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(cmd_push),
        .wdata(cmd_in),
        .full (full),
        .rd_en(cmd_pop),
        .rdata(cmd_rdata),
        .empty(cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_rdata);

    u8gb_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_entries(table_entries_reg),
        .cmd          (cmd_out),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res_in)
    );

    // Hold finished results until the consumer pops them.
    u8gb_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(res_push),
        .wdata(res_in),
        .full (res_full),
        .rd_en(pop),
        .rdata(res_rdata),
        .empty(empty)
    );

    assign res_out     = result_t'(res_rdata);
    assign out_byte    = res_out.out_byte;
    assign last        = res_out.last;
    assign lookup_miss = res_out.miss;
    assign seq_error   = res_out.err;

    a_err_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && seq_error) |-> (out_byte == 8'h00 && last && !lookup_miss))
        else $error("error result carries data");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && lookup_miss) |-> (out_byte == 8'h00 && !seq_error))
        else $error("miss result carries data");

    a_cfg_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && reg_sel) |=> (table_entries_reg == $past(pwdata[13:0])))
        else $error("table_entries write lost");

endmodule
